FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check a consequence in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lct_pkg.sv
package lct_pkg;

  localparam int MAX_EV    = 3;
  localparam int EV_IDX_W  = $clog2(MAX_EV);
  localparam int CNT_W     = $clog2(MAX_EV + 1);
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_VT        = 8'h0B;
  localparam logic [7:0] CH_FF        = 8'h0C;

  localparam logic CFG_IDX_CONT_EN = 1'b0;

  typedef enum logic [1:0] {
    EV_BYTE      = 2'd0,
    EV_TOKEN_END = 2'd1,
    EV_EOL       = 2'd2,
    EV_EOF       = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       start;
    logic       last;
  } event_t;

  typedef struct packed {
    logic pend_bs;
    logic pend_cr;
    logic in_tok;
  } state_t;

endpackage

FILE: rtl/lct_in_if.sv
interface lct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

FILE: rtl/lct_out_if.sv
interface lct_out_if
  import lct_pkg::*;
();
  logic       valid;
  logic       ready;
  kind_t      event_kind;
  logic [7:0] out_byte;
  logic       token_start;
  logic       last_of_run;

  modport source (output valid, event_kind, out_byte, token_start, last_of_run, input ready);
  modport sink   (input valid, event_kind, out_byte, token_start, last_of_run, output ready);
endinterface

FILE: rtl/lct_events.sv
module lct_events
  import lct_pkg::*;
(
  input  logic                      in_eoi,
  input  logic [7:0]                in_data,
  input  logic                      cont_en,
  input  state_t                    st_cur,
  output state_t                    st_nxt,
  output event_t [MAX_EV-1:0]       ev,
  output logic   [CNT_W-1:0]        ev_cnt
);

  state_t                st;
  event_t [MAX_EV-1:0]   evs;
  logic   [EV_IDX_W-1:0] n;
  logic                  done;
  logic                  is_eol;
  logic                  is_ws;

  always_comb begin
    st     = st_cur;
    evs    = '0;
    n      = '0;
    done   = 1'b0;
    is_eol = (in_data == CH_CR) || (in_data == CH_LF);
    is_ws  = (in_data == CH_SPACE) || (in_data == CH_TAB) ||
             (in_data == CH_VT) || (in_data == CH_FF);

    if (in_eoi) begin
      if (st.pend_bs) begin
        evs[n] = '{kind: EV_BYTE, data: CH_BACKSLASH, start: !st.in_tok, last: 1'b0};
        n = n + EV_IDX_W'(1);
        st.in_tok = 1'b1;
      end
      if (st.in_tok) begin
        evs[n] = '{kind: EV_TOKEN_END, data: 8'h00, start: 1'b0, last: 1'b0};
        n = n + EV_IDX_W'(1);
      end
      evs[n] = '{kind: EV_EOF, data: 8'h00, start: 1'b0, last: 1'b0};
      n = n + EV_IDX_W'(1);
      st = '0;
    end else begin
      if (st.pend_cr) begin
        st.pend_cr = 1'b0;
        if (in_data == CH_LF) begin
          done = 1'b1;
        end
      end
      if (!done && st.pend_bs) begin
        st.pend_bs = 1'b0;
        if (is_eol) begin
          if (st.in_tok) begin
            evs[n] = '{kind: EV_TOKEN_END, data: 8'h00, start: 1'b0, last: 1'b0};
            n = n + EV_IDX_W'(1);
            st.in_tok = 1'b0;
          end
          st.pend_cr = (in_data == CH_CR);
          done = 1'b1;
        end else begin
          evs[n] = '{kind: EV_BYTE, data: CH_BACKSLASH, start: !st.in_tok, last: 1'b0};
          n = n + EV_IDX_W'(1);
          st.in_tok = 1'b1;
        end
      end
      if (!done) begin
        if (is_eol) begin
          if (st.in_tok) begin
            evs[n] = '{kind: EV_TOKEN_END, data: 8'h00, start: 1'b0, last: 1'b0};
            n = n + EV_IDX_W'(1);
            st.in_tok = 1'b0;
          end
          evs[n] = '{kind: EV_EOL, data: 8'h00, start: 1'b0, last: 1'b0};
          n = n + EV_IDX_W'(1);
          st.pend_cr = (in_data == CH_CR);
        end else if ((in_data == CH_BACKSLASH) && cont_en) begin
          st.pend_bs = 1'b1;
        end else if (is_ws) begin
          if (st.in_tok) begin
            evs[n] = '{kind: EV_TOKEN_END, data: 8'h00, start: 1'b0, last: 1'b0};
            n = n + EV_IDX_W'(1);
            st.in_tok = 1'b0;
          end
        end else begin
          evs[n] = '{kind: EV_BYTE, data: in_data, start: !st.in_tok, last: 1'b0};
          n = n + EV_IDX_W'(1);
          st.in_tok = 1'b1;
        end
      end
    end

    if (n != '0) begin
      evs[n - EV_IDX_W'(1)].last = 1'b1;
    end
  end

  assign st_nxt = st;
  assign ev     = evs;
  assign ev_cnt = CNT_W'(n);

endmodule

FILE: rtl/line_continuation_tokenizer.sv
// Line continuation tokenizer.
// Input channel in_ch carries one text byte per transfer, or an end-of-input
// marker (end_of_input high, byte ignored). Output channel out_ch carries
// token events: token byte with start flag, token end, end of line, end of
// file; last_of_run marks the final event caused by one input transfer.
// Each input transfer yields zero to three events, which are written at the
// accepting edge into an eight-entry event queue; the head of the queue
// drives out_ch. Throughput is one input byte per cycle while the queue has
// room for three events; the output drains one event per cycle while
// out_ch.ready is high, so only bursts of events above one per byte slow the
// input. in_ch.ready drops when fewer than three queue entries are free, so a
// stalled receiver backs up into the input.
// Register 0 at cfg address 0 is continuation_enable, write it while idle.
// Reset (rst_n low, synchronous) empties the queue, clears the backslash,
// CR and open-token state, and sets continuation_enable to 1.
// An end-of-input transfer emits a pending backslash as a token byte, closes
// any open token, emits end of file and clears the tokenizer state.
module line_continuation_tokenizer
  import lct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lct_in_if.sink            in_ch,
  lct_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  `include "assert_macros.svh"

  logic                cont_en_r;
  state_t              st_r;
  state_t              st_nxt;
  event_t [MAX_EV-1:0] ev;
  logic   [CNT_W-1:0]  ev_cnt;

  event_t              q_mem [QDEPTH];
  logic   [QPTR_W-1:0] wr_ptr_r;
  logic   [QPTR_W-1:0] rd_ptr_r;
  logic   [QCNT_W-1:0] count_r;
  logic   [QCNT_W-1:0] count_nxt;
  logic   [CNT_W-1:0]  n_wr;

  logic in_xfer;
  logic out_xfer;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_CONT_EN) ? {{(CFG_DW-1){1'b0}}, cont_en_r}
                                                         : '0;

  assign in_ch.ready = (count_r <= QCNT_W'(QDEPTH - MAX_EV));
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = out_ch.valid && out_ch.ready;

  lct_events u_events (
    .in_eoi  (in_ch.end_of_input),
    .in_data (in_ch.in_byte),
    .cont_en (cont_en_r),
    .st_cur  (st_r),
    .st_nxt  (st_nxt),
    .ev      (ev),
    .ev_cnt  (ev_cnt)
  );

  assign n_wr      = in_xfer ? ev_cnt : '0;
  assign count_nxt = count_r + QCNT_W'(n_wr) - QCNT_W'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_en_r <= 1'b1;
      st_r      <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
    end else begin
      if (cfg_wr && (cfg_paddr[2] == CFG_IDX_CONT_EN)) begin
        cont_en_r <= cfg_pwdata[0];
      end
      if (in_xfer) begin
        st_r <= st_nxt;
      end
      wr_ptr_r <= wr_ptr_r + QPTR_W'(n_wr);
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_EV; i++) begin
      if (CNT_W'(i) < n_wr) begin
        q_mem[wr_ptr_r + QPTR_W'(i)] <= ev[i];
      end
    end
  end

  assign out_ch.valid       = (count_r != '0);
  assign out_ch.event_kind  = q_mem[rd_ptr_r].kind;
  assign out_ch.out_byte    = q_mem[rd_ptr_r].data;
  assign out_ch.token_start = q_mem[rd_ptr_r].start;
  assign out_ch.last_of_run = q_mem[rd_ptr_r].last;

  `ASSERT_ALWAYS(a_q_bound, clk, rst_n, count_r <= QCNT_W'(QDEPTH), "event queue overflow")
  `ASSERT_NEXT(a_eof_clear, clk, rst_n, in_xfer && in_ch.end_of_input, st_r == '0, "state not cleared after end of input")
  `ASSERT_NEXT(a_drain_one, clk, rst_n, out_xfer && !in_xfer, count_r == $past(count_r) - QCNT_W'(1), "queue count off after output transfer")

endmodule
